### rtl/ntc_adc_to_temperature_macros.svh
// Assertion macros shared by the ntc_adc_to_temperature RTL.
// Each macro expects clk_i and rst_ni in scope at the point of use.
`ifndef NTC_ADC_TO_TEMPERATURE_MACROS_SVH
`define NTC_ADC_TO_TEMPERATURE_MACROS_SVH

// Same-cycle implication.
`define NTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NTC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must never hold.
`define NTC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

### rtl/ntc_pkg.sv
// Shared types, constants and calibration ROM for the NTC converter.
// No dependencies; used by ntc_ctrl, ntc_dp and ntc_adc_to_temperature.
package ntc_pkg;

  localparam int ROM_POINTS   = 34;
  localparam int TABLE_POINTS = 34;
  localparam int ROM_IDX_W    = 6;
  localparam int ADC_W        = 12;
  localparam int TEMP_W       = 12;
  localparam int PROD_W       = 2 * ADC_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEARCH,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    RES_LAST,
    RES_FIRST,
    RES_ZERO,
    RES_HI,
    RES_INTERP
  } res_sel_e;

  typedef struct packed {
    logic     load_in;
    logic     clr_idx;
    logic     inc_idx;
    logic     load_seg;
    logic     load_prod;
    logic     div_step;
    logic     load_res;
    res_sel_e res_sel;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic below_last;
    logic above_first;
    logic seg_hit;
    logic span_zero;
    logic idx_last;
    logic div_last;
  } sts_t;

  function automatic logic [ADC_W-1:0] rom_code(input logic [ROM_IDX_W-1:0] idx);
    logic [ADC_W-1:0] c;
    unique case (idx)
      6'd0:  c = 12'd3902;
      6'd1:  c = 12'd3839;
      6'd2:  c = 12'd3767;
      6'd3:  c = 12'd3681;
      6'd4:  c = 12'd3579;
      6'd5:  c = 12'd3458;
      6'd6:  c = 12'd3322;
      6'd7:  c = 12'd3171;
      6'd8:  c = 12'd3003;
      6'd9:  c = 12'd2823;
      6'd10: c = 12'd2636;
      6'd11: c = 12'd2439;
      6'd12: c = 12'd2243;
      6'd13: c = 12'd2048;
      6'd14: c = 12'd1859;
      6'd15: c = 12'd1678;
      6'd16: c = 12'd1508;
      6'd17: c = 12'd1349;
      6'd18: c = 12'd1204;
      6'd19: c = 12'd1071;
      6'd20: c = 12'd951;
      6'd21: c = 12'd843;
      6'd22: c = 12'd747;
      6'd23: c = 12'd660;
      6'd24: c = 12'd582;
      6'd25: c = 12'd512;
      6'd26: c = 12'd449;
      6'd27: c = 12'd392;
      6'd28: c = 12'd342;
      6'd29: c = 12'd296;
      6'd30: c = 12'd256;
      6'd31: c = 12'd220;
      6'd32: c = 12'd189;
      6'd33: c = 12'd161;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic signed [TEMP_W-1:0] rom_tenths(
    input logic [ROM_IDX_W-1:0] idx
  );
    logic signed [TEMP_W-1:0] t;
    unique case (idx)
      6'd0:  t = -12'sd400;
      6'd1:  t = -12'sd350;
      6'd2:  t = -12'sd300;
      6'd3:  t = -12'sd250;
      6'd4:  t = -12'sd200;
      6'd5:  t = -12'sd150;
      6'd6:  t = -12'sd100;
      6'd7:  t = -12'sd50;
      6'd8:  t = 12'sd0;
      6'd9:  t = 12'sd50;
      6'd10: t = 12'sd100;
      6'd11: t = 12'sd150;
      6'd12: t = 12'sd200;
      6'd13: t = 12'sd250;
      6'd14: t = 12'sd300;
      6'd15: t = 12'sd350;
      6'd16: t = 12'sd400;
      6'd17: t = 12'sd450;
      6'd18: t = 12'sd500;
      6'd19: t = 12'sd550;
      6'd20: t = 12'sd600;
      6'd21: t = 12'sd650;
      6'd22: t = 12'sd700;
      6'd23: t = 12'sd750;
      6'd24: t = 12'sd800;
      6'd25: t = 12'sd850;
      6'd26: t = 12'sd900;
      6'd27: t = 12'sd950;
      6'd28: t = 12'sd1000;
      6'd29: t = 12'sd1050;
      6'd30: t = 12'sd1100;
      6'd31: t = 12'sd1150;
      6'd32: t = 12'sd1200;
      6'd33: t = 12'sd1250;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

### rtl/ntc_ctrl.sv
// Sequencer for the NTC converter: clamp check, segment search, multiply,
// serial divide and output hand-off. Depends on ntc_pkg and the macro header.
`include "ntc_adc_to_temperature_macros.svh"

module ntc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  ntc_pkg::sts_t sts_i,
  output ntc_pkg::cmd_t cmd_o
);
  import ntc_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  cmd_t   cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd         = '0;
    cmd.res_sel = RES_ZERO;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.load_in = 1'b1;
          cmd.clr_idx = 1'b1;
          state_d     = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (sts_i.below_last) begin
          cmd.load_res = 1'b1;
          cmd.res_sel  = RES_LAST;
          state_d      = ST_OUT;
        end else if (sts_i.above_first) begin
          cmd.load_res = 1'b1;
          cmd.res_sel  = RES_FIRST;
          state_d      = ST_OUT;
        end else begin
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        priority if (sts_i.seg_hit && sts_i.span_zero) begin
          cmd.load_res = 1'b1;
          cmd.res_sel  = RES_HI;
          state_d      = ST_OUT;
        end else if (sts_i.seg_hit) begin
          cmd.load_seg = 1'b1;
          state_d      = ST_MUL;
        end else if (sts_i.idx_last) begin
          cmd.load_res = 1'b1;
          cmd.res_sel  = RES_ZERO;
          state_d      = ST_OUT;
        end else begin
          cmd.inc_idx = 1'b1;
        end
      end
      ST_MUL: begin
        cmd.load_prod = 1'b1;
        state_d       = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.load_res = 1'b1;
        cmd.res_sel  = RES_INTERP;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd.load_out = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result register holds while the consumer stalls
  assign out_valid_d = (out_valid_q && out_stall_i) || cmd.load_out;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  `NTC_ASSERT_IMP(a_out_slot_free, cmd.load_out, !out_valid_q || !out_stall_i, "output overwritten while stalled")
  `NTC_ASSERT_NXT(a_accept_to_check, in_valid_i && !in_stall_o, state_q == ST_CHECK, "accept did not start clamp check")
  `NTC_ASSERT_NXT(a_div_to_fin, state_q == ST_DIV && sts_i.div_last, state_q == ST_FIN, "divider end missed")
  `NTC_ASSERT_NEVER(a_res_out_overlap, cmd.load_res && cmd.load_out, "result load and output load overlap")

endmodule

### rtl/ntc_dp.sv
// Datapath for the NTC converter: input register, segment index, multiplier,
// restoring divider and result/output registers. Depends on ntc_pkg.
module ntc_dp #(
  parameter int TablePoints = ntc_pkg::TABLE_POINTS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [ntc_pkg::ADC_W-1:0]          adc_sample_i,
  input  ntc_pkg::cmd_t                      cmd_i,
  output ntc_pkg::sts_t                      sts_o,
  output logic signed [ntc_pkg::TEMP_W-1:0]  temperature_tenths_o
);
  import ntc_pkg::*;

  localparam int NPoints = (TablePoints > ROM_POINTS) ? ROM_POINTS :
                           ((TablePoints < 2) ? 2 : TablePoints);
  localparam int IdxW    = $clog2(NPoints);
  localparam int CntW    = $clog2(PROD_W);

  logic [ADC_W-1:0]         adc_q;
  logic [IdxW-1:0]          idx_q;
  logic [ADC_W-1:0]         off_q;
  logic [ADC_W-1:0]         span_q;
  logic [TEMP_W-1:0]        rise_mag_q;
  logic                     neg_q;
  logic signed [TEMP_W-1:0] lo_tenths_q;
  logic [PROD_W-1:0]        quo_q;
  logic [ADC_W-1:0]         rem_q;
  logic [CntW-1:0]          cnt_q;
  logic signed [TEMP_W-1:0] res_q;
  logic signed [TEMP_W-1:0] dout_q;

  logic [ROM_IDX_W-1:0]     rom_hi_idx, rom_lo_idx;
  logic [ADC_W-1:0]         code_hi, code_lo, code_first, code_last;
  logic signed [TEMP_W-1:0] tenths_hi, tenths_lo;
  logic signed [TEMP_W:0]   rise;
  logic [TEMP_W:0]          rise_abs;
  logic [ADC_W:0]           rem_sh;
  logic                     rem_ge;
  logic [TEMP_W-1:0]        quo_lsb;
  logic signed [TEMP_W-1:0] interp;
  logic signed [TEMP_W-1:0] res_d;

  assign rom_hi_idx = ROM_IDX_W'(idx_q);
  assign rom_lo_idx = ROM_IDX_W'(IdxW'(idx_q + 1'b1));
  assign code_hi    = rom_code(rom_hi_idx);
  assign code_lo    = rom_code(rom_lo_idx);
  assign tenths_hi  = rom_tenths(rom_hi_idx);
  assign tenths_lo  = rom_tenths(rom_lo_idx);
  assign code_first = rom_code('0);
  assign code_last  = rom_code(ROM_IDX_W'(NPoints - 1));

  assign rise     = (TEMP_W + 1)'(tenths_hi) - (TEMP_W + 1)'(tenths_lo);
  assign rise_abs = rise[TEMP_W] ? (TEMP_W + 1)'(-rise) : rise;

  // one restoring divide step per cycle, quotient shifts in at the bottom
  assign rem_sh = {rem_q, quo_q[PROD_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, span_q});

  assign quo_lsb = quo_q[TEMP_W-1:0];
  assign interp  = neg_q ? (lo_tenths_q - $signed(quo_lsb))
                         : (lo_tenths_q + $signed(quo_lsb));

  always_comb begin
    unique case (cmd_i.res_sel)
      RES_LAST:   res_d = rom_tenths(ROM_IDX_W'(NPoints - 1));
      RES_FIRST:  res_d = rom_tenths('0);
      RES_HI:     res_d = tenths_hi;
      RES_INTERP: res_d = interp;
      RES_ZERO:   res_d = '0;
      default:    res_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.clr_idx) begin
        idx_q <= '0;
      end else if (cmd_i.inc_idx) begin
        idx_q <= IdxW'(idx_q + 1'b1);
      end
      if (cmd_i.load_prod) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= CntW'(cnt_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      adc_q <= adc_sample_i;
    end
    if (cmd_i.load_seg) begin
      off_q       <= adc_q - code_lo;
      span_q      <= code_hi - code_lo;
      rise_mag_q  <= rise_abs[TEMP_W-1:0];
      neg_q       <= rise[TEMP_W];
      lo_tenths_q <= tenths_lo;
    end
    if (cmd_i.load_prod) begin
      quo_q <= PROD_W'(rise_mag_q) * PROD_W'(off_q);
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[PROD_W-2:0], rem_ge};
      rem_q <= rem_ge ? ADC_W'(rem_sh - {1'b0, span_q}) : rem_sh[ADC_W-1:0];
    end
    if (cmd_i.load_res) begin
      res_q <= res_d;
    end
    if (cmd_i.load_out) begin
      dout_q <= res_q;
    end
  end

  assign sts_o.below_last  = (adc_q <= code_last);
  assign sts_o.above_first = (adc_q >= code_first);
  assign sts_o.seg_hit     = (adc_q >= code_lo) && (adc_q <= code_hi);
  assign sts_o.span_zero   = (code_hi == code_lo);
  assign sts_o.idx_last    = (idx_q == IdxW'(NPoints - 2));
  assign sts_o.div_last    = (cnt_q == CntW'(PROD_W - 1));

  assign temperature_tenths_o = dout_q;

endmodule

### rtl/ntc_adc_to_temperature.sv
// Converts a 12-bit thermistor ADC sample to temperature in 0.1 C by
// piecewise-linear interpolation over a 34-point calibration ROM. Each sample
// is checked against both clamp limits, then the segments are scanned one per
// cycle, and the offset is scaled by one 12x12 multiply and a restoring
// divider. The segment scan and the one-bit-per-cycle divider set the
// conversion time. One sample is in work at a time; a new sample is taken as
// soon as the previous result has moved into the output register, even while
// the consumer still stalls it. TablePoints selects how many ROM points are in
// use (at most the 34 held in the ROM).
module ntc_adc_to_temperature #(
  parameter int TablePoints = ntc_pkg::TABLE_POINTS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [ntc_pkg::ADC_W-1:0]         adc_sample_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [ntc_pkg::TEMP_W-1:0] temperature_tenths_o
);
  import ntc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ntc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ntc_dp #(
    .TablePoints (TablePoints)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .adc_sample_i         (adc_sample_i),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .temperature_tenths_o (temperature_tenths_o)
  );

endmodule

### tb/sv/ntc_temp_checker.sv
// Scoreboard for ntc_adc_to_temperature: watches both channels, predicts the
// converted temperature for each accepted sample and compares it in order.
// Depends on ntc_pkg for field widths and the default table size only.
module ntc_temp_checker #(
  parameter int TablePoints = ntc_pkg::TABLE_POINTS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [ntc_pkg::ADC_W-1:0]         adc_sample_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic signed [ntc_pkg::TEMP_W-1:0] temperature_tenths_i,
  output int                                err_count_o,
  output int                                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [ntc_pkg::ADC_W-1:0]         sample;
    logic signed [ntc_pkg::TEMP_W-1:0] tenths;
  } temp_expect_t;

  localparam int CalPoints = 34;

  // calibration curve: ADC code falls as temperature rises
  int cal_code [0:CalPoints-1] = '{
    3902, 3839, 3767, 3681, 3579, 3458, 3322, 3171, 3003, 2823, 2636, 2439,
    2243, 2048, 1859, 1678, 1508, 1349, 1204, 1071,  951,  843,  747,  660,
     582,  512,  449,  392,  342,  296,  256,  220,  189,  161};
  int cal_tenths [0:CalPoints-1] = '{
    -400, -350, -300, -250, -200, -150, -100,  -50,    0,   50,  100,  150,
     200,  250,  300,  350,  400,  450,  500,  550,  600,  650,  700,  750,
     800,  850,  900,  950, 1000, 1050, 1100, 1150, 1200, 1250};

  temp_expect_t expected_temps[$];
  int           err_count = 0;

  assign err_count_o = err_count;
  assign pending_o   = expected_temps.size();

  function automatic logic signed [ntc_pkg::TEMP_W-1:0] tenths_for_sample(
    input logic [ntc_pkg::ADC_W-1:0] adc
  );
    int npts, a, seg, span, rise, off, t;
    bit hit;
    npts = TablePoints;
    if (npts > CalPoints) npts = CalPoints;
    if (npts < 1) npts = 1;
    a = int'(adc);
    t = 0;
    hit = 1'b0;
    if (a <= cal_code[npts-1]) begin
      t = cal_tenths[npts-1];
    end else if (a >= cal_code[0]) begin
      t = cal_tenths[0];
    end else begin
      // first segment that contains the sample wins (shared end codes)
      for (seg = 0; seg + 1 < npts; seg++) begin
        if (!hit && a >= cal_code[seg+1] && a <= cal_code[seg]) begin
          hit  = 1'b1;
          span = cal_code[seg] - cal_code[seg+1];
          rise = cal_tenths[seg] - cal_tenths[seg+1];
          off  = a - cal_code[seg+1];
          if (span == 0) t = cal_tenths[seg];
          else t = cal_tenths[seg+1] + (rise * off) / span;
        end
      end
    end
    return t[ntc_pkg::TEMP_W-1:0];
  endfunction

  always @(posedge clk_i) begin
    temp_expect_t exp_item;
    temp_expect_t got_front;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        exp_item.sample = adc_sample_i;
        exp_item.tenths = tenths_for_sample(adc_sample_i);
        expected_temps.push_back(exp_item);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_temps.size() == 0) begin
          $display("%0t: unexpected result transaction, actual %0d",
                   $realtime, temperature_tenths_i);
          err_count++;
        end else begin
          got_front = expected_temps.pop_front();
          if (temperature_tenths_i !== got_front.tenths) begin
            $display("%0t: temperature mismatch for adc %0d: expected %0d, actual %0d",
                     $realtime, got_front.sample, got_front.tenths,
                     temperature_tenths_i);
            err_count++;
          end
        end
      end
    end
  end

endmodule

### tb/sv/ntc_adc_to_temperature_tb.sv
// Top of the ntc_adc_to_temperature testbench: clock, reset, sample stimulus,
// random output stalls and the verdict. Depends on ntc_pkg, the block itself
// and the ntc_temp_checker scoreboard.
module ntc_adc_to_temperature_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRandom = 1700;
  localparam int DrainCycles = 200;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              in_valid_i = 1'b0;
  logic                              in_stall_o;
  logic [ntc_pkg::ADC_W-1:0]         adc_sample_i = '0;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic signed [ntc_pkg::TEMP_W-1:0] temperature_tenths_o;
  int                                err_count;
  int                                pending;
  int                                calm_left = 0;

  ntc_adc_to_temperature DUT (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .adc_sample_i         (adc_sample_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .temperature_tenths_o (temperature_tenths_o)
  );

  ntc_temp_checker u_checker (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_i           (in_stall_o),
    .adc_sample_i         (adc_sample_i),
    .out_valid_i          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .temperature_tenths_i (temperature_tenths_o),
    .err_count_o          (err_count),
    .pending_o            (pending)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_sample(input logic [ntc_pkg::ADC_W-1:0] sample);
    int gap;
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else if ($urandom_range(0, 39) == 0) begin
      calm_left = $urandom_range(20, 80);
      gap = 0;
    end else begin
      gap = idle_len();
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    adc_sample_i <= sample;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // sender holds off until every converted sample is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic [ntc_pkg::ADC_W-1:0] random_sample();
    int r, base, s;
    int hot_codes [0:9] = '{3902, 3003, 2048, 1508, 951, 582, 342, 220, 189, 161};
    r = $urandom_range(0, 99);
    if (r < 55) begin
      s = $urandom_range(0, 4095);
    end else if (r < 80) begin
      // land right around a calibration code
      base = hot_codes[$urandom_range(0, 9)];
      s = base + $urandom_range(0, 6) - 3;
    end else if (r < 90) begin
      s = $urandom_range(0, 1) ? $urandom_range(0, 161) : $urandom_range(3902, 4095);
    end else begin
      s = $urandom_range(161, 3902);
    end
    return s[ntc_pkg::ADC_W-1:0];
  endfunction

  // output side: random stalls with calm stretches
  initial begin
    int stall;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 9) < 2) begin
        repeat ($urandom_range(20, 200)) @(negedge clk_i);
      end else begin
        stall = idle_len();
        if (stall > 0) begin
          out_stall_i <= 1'b1;
          repeat (stall) @(negedge clk_i);
        end
        out_stall_i <= 1'b0;
        @(negedge clk_i);
      end
    end
  end

  initial begin
    logic [ntc_pkg::ADC_W-1:0] directed [0:23] = '{
      12'd0, 12'd4095, 12'd160, 12'd161, 12'd162, 12'd3901, 12'd3902,
      12'd3903, 12'd2048, 12'd2047, 12'd2049, 12'd3003, 12'd3004, 12'd3002,
      12'd1000, 12'd189, 12'd190, 12'd951, 12'hAAA, 12'h555, 12'd4094,
      12'd1, 12'd2823, 12'd3839};
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[k]) send_sample(directed[k]);
    drain_results();

    for (int k = 0; k < NumRandom; k++) begin
      send_sample(random_sample());
      if (k == NumRandom / 2) drain_results();
    end

    drain_results();
    repeat (DrainCycles) @(negedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/ntc_pkg.sv
rtl/ntc_ctrl.sv
rtl/ntc_dp.sv
rtl/ntc_adc_to_temperature.sv
tb/sv/ntc_temp_checker.sv
tb/sv/ntc_adc_to_temperature_tb.sv
